@@ rtl/sliding_window_pair_sum_check_unit_macros.svh @@
// Assertion macros shared by the pair-sum check RTL.
`ifndef SLIDING_WINDOW_PAIR_SUM_CHECK_UNIT_MACROS_SVH
`define SLIDING_WINDOW_PAIR_SUM_CHECK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SWPSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SWPSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/swpsc_pkg.sv @@
// Shared types and constants for the sliding-window pair-sum checker.
package swpsc_pkg;

   localparam int VALUE_W = 64;
   localparam int RSP_W   = 8;

   localparam int RSP_TESTED_BIT = 0;
   localparam int RSP_FOUND_BIT  = 1;
   localparam int RSP_FIRST_BIT  = 2;

   // Sequencer commands from the top level to the pair scanner
   typedef struct packed {
      logic               start;
      logic               store;
      logic [VALUE_W-1:0] value;
   } scan_ctrl_type;

   // Scanner status back to the top level
   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } scan_stat_type;

endpackage

@@ rtl/swpsc_scan.sv @@
// Window store and shared 65-bit add/compare unit that walks all position pairs.
`include "sliding_window_pair_sum_check_unit_macros.svh"

module swpsc_scan #(
   parameter int WINDOW = 25,
   localparam int IW    = $clog2(WINDOW)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  swpsc_pkg::scan_ctrl_type ctrl,
   input  logic [IW-1:0]           wr_addr,
   output swpsc_pkg::scan_stat_type stat
);

   logic [swpsc_pkg::VALUE_W-1:0] mem_ff [WINDOW];
   logic [swpsc_pkg::VALUE_W-1:0] rd_a_ff, rd_b_ff;

   logic          issue_ff, issue_in;
   logic [IW-1:0] i_ff, i_in;
   logic [IW-1:0] j_ff, j_in;
   logic          pv_ff, pv_in;
   logic          pl_ff, pl_in;
   logic          found_ff, found_in;
   logic          done_ff, done_in;
   logic          is_last;
   logic          match;
   logic [swpsc_pkg::VALUE_W:0] sum;

   // Ring store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (ctrl.store) begin
         mem_ff[wr_addr] <= ctrl.value;
      end
      rd_a_ff <= mem_ff[i_ff];
      rd_b_ff <= mem_ff[j_ff];
   end

   always_comb begin
      issue_in = issue_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      is_last  = issue_ff && (j_ff == IW'(WINDOW - 1)) && (i_ff == IW'(WINDOW - 2));
      if (ctrl.start) begin
         issue_in = 1'b1;
         i_in     = '0;
         j_in     = IW'(1);
      end else if (issue_ff) begin
         if (j_ff == IW'(WINDOW - 1)) begin
            if (i_ff == IW'(WINDOW - 2)) begin
               issue_in = 1'b0;
            end else begin
               i_in = i_ff + IW'(1);
               j_in = i_ff + IW'(2);
            end
         end else begin
            j_in = j_ff + IW'(1);
         end
      end

      pv_in = issue_ff;
      pl_in = is_last;

      // Sign-extended sum never wraps, so an out-of-range pair cannot match
      sum      = {rd_a_ff[swpsc_pkg::VALUE_W-1], rd_a_ff}
               + {rd_b_ff[swpsc_pkg::VALUE_W-1], rd_b_ff};
      match    = pv_ff && (sum == {ctrl.value[swpsc_pkg::VALUE_W-1], ctrl.value});
      found_in = ctrl.start ? 1'b0 : (found_ff | match);
      done_in  = pv_ff && pl_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         pv_ff    <= 1'b0;
         pl_ff    <= 1'b0;
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         issue_ff <= issue_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         pv_ff    <= pv_in;
         pl_ff    <= pl_in;
         found_ff <= found_in;
         done_ff  <= done_in;
      end
   end

   assign stat.busy  = issue_ff | pv_ff | done_ff;
   assign stat.done  = done_ff;
   assign stat.found = found_ff;

   `SWPSC_ASSERT_NOW(a_pair_order, clock, reset, issue_ff, j_ff > i_ff, "pair index order broken")
   `SWPSC_ASSERT_NOW(a_start_idle, clock, reset, ctrl.start, !stat.busy, "scan started while busy")
   `SWPSC_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff && !issue_ff, "done not a single pulse")

endmodule

@@ rtl/sliding_window_pair_sum_check_unit.sv @@
// Top level of the sliding-window pair-sum checker: handshake, ring bookkeeping, result register.
//
//   channel  dir  tdata bits (lsb first)                        tlast/tuser
//   req_     in   [63:0] value (signed)                         none
//   rsp_     out  [0] tested [1] pair_found [2] first_failure   none
//
// A tested item is checked by one shared 65-bit adder/comparator, which
// checks one position pair per cycle.
// Items arriving while the window fills skip the scan and are reported untested.
// req_tready is high only between items; a result waits in the output register.
// Synchronous active-high reset; the window store itself is not cleared.

`include "sliding_window_pair_sum_check_unit_macros.svh"

module sliding_window_pair_sum_check_unit #(
   parameter int WINDOW = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [swpsc_pkg::VALUE_W-1:0] req_tdata,  // [63:0] value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [swpsc_pkg::RSP_W-1:0]   rsp_tdata   // [0] tested [1] pair_found [2] first_failure
);

   localparam int IW = $clog2(WINDOW);
   localparam int FW = $clog2(WINDOW + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_POST} state_type;

   state_type                     state_ff, state_in;
   logic [swpsc_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                          tested_ff, tested_in;
   logic                          found_ff, found_in;
   logic                          failure_seen_ff, failure_seen_in;
   logic [IW-1:0]                 slot_ff, slot_in;
   logic [FW-1:0]                 fill_ff, fill_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swpsc_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   swpsc_pkg::scan_ctrl_type ctrl;
   swpsc_pkg::scan_stat_type stat;

   logic full;
   logic rsp_free;
   logic first;

   swpsc_scan #(.WINDOW(WINDOW)) u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .wr_addr (slot_ff),
      .stat    (stat)
   );

   always_comb begin
      state_in        = state_ff;
      value_in        = value_ff;
      tested_in       = tested_ff;
      found_in        = found_ff;
      failure_seen_in = failure_seen_ff;
      slot_in         = slot_ff;
      fill_in         = fill_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      ctrl.start      = 1'b0;
      ctrl.store      = 1'b0;
      ctrl.value      = value_ff;

      full     = (fill_ff == FW'(WINDOW));
      rsp_free = !rsp_valid_ff || rsp_tready;
      first    = tested_ff && !found_ff && !failure_seen_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in   = req_tdata;
               tested_in  = full;
               found_in   = 1'b0;
               ctrl.start = full;
               state_in   = full ? ST_SCAN : ST_POST;
            end
         end
         ST_SCAN: begin
            if (stat.done) begin
               found_in = stat.found;
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (rsp_free) begin
               // Item is finished: store it in the next ring slot (the oldest entry once full) and report
               ctrl.store      = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_data_in     = '0;
               rsp_data_in[swpsc_pkg::RSP_TESTED_BIT] = tested_ff;
               rsp_data_in[swpsc_pkg::RSP_FOUND_BIT]  = found_ff;
               rsp_data_in[swpsc_pkg::RSP_FIRST_BIT]  = first;
               failure_seen_in = failure_seen_ff | first;
               slot_in         = (slot_ff == IW'(WINDOW - 1)) ? '0 : slot_ff + IW'(1);
               if (!full) begin
                  fill_in = fill_ff + FW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tested_ff       <= 1'b0;
         found_ff        <= 1'b0;
         failure_seen_ff <= 1'b0;
         slot_ff         <= '0;
         fill_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tested_ff       <= tested_in;
         found_ff        <= found_in;
         failure_seen_ff <= failure_seen_in;
         slot_ff         <= slot_in;
         fill_ff         <= fill_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SWPSC_ASSERT_NOW(a_found_tested, clock, reset,
      rsp_tvalid && rsp_tdata[swpsc_pkg::RSP_FOUND_BIT],
      rsp_tdata[swpsc_pkg::RSP_TESTED_BIT], "pair found on untested item")
   `SWPSC_ASSERT_NOW(a_first_clean, clock, reset,
      rsp_tvalid && rsp_tdata[swpsc_pkg::RSP_FIRST_BIT],
      rsp_tdata[swpsc_pkg::RSP_TESTED_BIT] && !rsp_tdata[swpsc_pkg::RSP_FOUND_BIT],
      "first failure flag inconsistent")
   `SWPSC_ASSERT_NOW(a_first_once, clock, reset, failure_seen_ff && ctrl.store, !first,
      "second first failure")
   `SWPSC_ASSERT_NOW(a_done_in_scan, clock, reset, stat.done, state_ff == ST_SCAN,
      "scan done outside scan state")
   `SWPSC_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= FW'(WINDOW),
      "fill count past window")

endmodule
